### rtl/calc_keyword_lexer_defines.svh
// ----------------------------------------------------------------------------
// calc_keyword_lexer assertion macros
// Shared concurrent assertion forms for the keyword lexer RTL.
// ----------------------------------------------------------------------------
`ifndef CALC_KEYWORD_LEXER_DEFINES_SVH
`define CALC_KEYWORD_LEXER_DEFINES_SVH

// Property must hold on every clock edge outside reset.
`define CKL_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("assertion failed: %m");

// Condition must never be seen outside reset.
`define CKL_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition: %m");

`endif

### rtl/ckl_pkg.sv
// ----------------------------------------------------------------------------
// ckl_pkg
// Types and constants of the calculator keyword lexer.
// ----------------------------------------------------------------------------
package ckl_pkg;

	// Partial keyword matched so far
	typedef enum logic [18:0] {
		ST_IDLE = 19'h00001,
		ST_L    = 19'h00002,
		ST_C    = 19'h00004,
		ST_CO   = 19'h00008,
		ST_A    = 19'h00010,
		ST_AC   = 19'h00020,
		ST_ACO  = 19'h00040,
		ST_AS   = 19'h00080,
		ST_ASI  = 19'h00100,
		ST_AT   = 19'h00200,
		ST_ATA  = 19'h00400,
		ST_S    = 19'h00800,
		ST_SI   = 19'h01000,
		ST_SQ   = 19'h02000,
		ST_SQR  = 19'h04000,
		ST_T    = 19'h08000,
		ST_TA   = 19'h10000,
		ST_M    = 19'h20000,
		ST_MO   = 19'h40000
	} state_t;

	// Token codes emitted for keywords
	localparam logic [7:0] CODE_LN   = "l";
	localparam logic [7:0] CODE_LG   = "L";
	localparam logic [7:0] CODE_COS  = "c";
	localparam logic [7:0] CODE_ACOS = "C";
	localparam logic [7:0] CODE_SIN  = "s";
	localparam logic [7:0] CODE_ASIN = "S";
	localparam logic [7:0] CODE_TAN  = "t";
	localparam logic [7:0] CODE_ATAN = "T";
	localparam logic [7:0] CODE_MOD  = "%";
	localparam logic [7:0] CODE_SQRT = "q";

	typedef struct packed {
		logic [7:0] code_char;
		logic       code_valid;
		logic       done_res;
		logic       bad_input;
	} res_t;

	typedef struct packed {
		state_t st;
		logic   err;
		logic   emit;
		res_t   res;
	} match_t;

endpackage

### rtl/ckl_if.sv
// ----------------------------------------------------------------------------
// ckl_if
// Handshake channels of the keyword lexer: character input and code output.
// ----------------------------------------------------------------------------
interface ckl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       in_last;

	modport source (output valid, output in_char, output in_last, input ready);
	modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface ckl_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_char;
	logic       code_valid;
	logic       done_res;
	logic       bad_input;

	modport source (output valid, output code_char, output code_valid,
		output done_res, output bad_input, input ready);
	modport sink   (input valid, input code_char, input code_valid,
		input done_res, input bad_input, output ready);
endinterface

### rtl/ckl_matcher.sv
// ----------------------------------------------------------------------------
// ckl_matcher
// Next-state and token logic of the keyword prefix machine for one item.
// ----------------------------------------------------------------------------
module ckl_matcher (
	input  ckl_pkg::state_t st,
	input  logic            err,
	input  logic [7:0]      ch,
	input  logic            last,
	output ckl_pkg::match_t m
);
	import ckl_pkg::*;

	state_t     nx;
	logic [7:0] code;
	logic       fail;
	state_t     st_adv;
	logic       err_adv;
	logic [7:0] code_e;
	logic       err_fin;

	function automatic logic is_plain(input logic [7:0] c);
		return c inside {["0":"9"], ".", "+", "-", "*", "/", "(", ")", "x", "^"};
	endfunction

	always_comb begin
		nx   = ST_IDLE;
		code = '0;
		fail = 1'b0;
		case (st)
			ST_IDLE: begin
				if (is_plain(ch)) begin
					code = ch;
				end else begin
					case (ch)
						" ": nx = ST_IDLE;
						"l": nx = ST_L;
						"c": nx = ST_C;
						"a": nx = ST_A;
						"s": nx = ST_S;
						"t": nx = ST_T;
						"m": nx = ST_M;
						default: fail = 1'b1;
					endcase
				end
			end
			ST_L: begin
				if (ch == "n") code = CODE_LN;
				else if (ch == "g") code = CODE_LG;
				else fail = 1'b1;
			end
			ST_C:   if (ch == "o") nx = ST_CO; else fail = 1'b1;
			ST_CO:  if (ch == "s") code = CODE_COS; else fail = 1'b1;
			ST_A: begin
				if (ch == "c") nx = ST_AC;
				else if (ch == "s") nx = ST_AS;
				else if (ch == "t") nx = ST_AT;
				else fail = 1'b1;
			end
			ST_AC:  if (ch == "o") nx = ST_ACO; else fail = 1'b1;
			ST_ACO: if (ch == "s") code = CODE_ACOS; else fail = 1'b1;
			ST_AS:  if (ch == "i") nx = ST_ASI; else fail = 1'b1;
			ST_ASI: if (ch == "n") code = CODE_ASIN; else fail = 1'b1;
			ST_AT:  if (ch == "a") nx = ST_ATA; else fail = 1'b1;
			ST_ATA: if (ch == "n") code = CODE_ATAN; else fail = 1'b1;
			ST_S: begin
				if (ch == "i") nx = ST_SI;
				else if (ch == "q") nx = ST_SQ;
				else fail = 1'b1;
			end
			ST_SI:  if (ch == "n") code = CODE_SIN; else fail = 1'b1;
			ST_SQ:  if (ch == "r") nx = ST_SQR; else fail = 1'b1;
			ST_SQR: if (ch == "t") code = CODE_SQRT; else fail = 1'b1;
			ST_T:   if (ch == "a") nx = ST_TA; else fail = 1'b1;
			ST_TA:  if (ch == "n") code = CODE_TAN; else fail = 1'b1;
			ST_M:   if (ch == "o") nx = ST_MO; else fail = 1'b1;
			ST_MO:  if (ch == "d") code = CODE_MOD; else fail = 1'b1;
			default: fail = 1'b1;
		endcase
	end

	// Once in error the machine is frozen until the end of the expression
	always_comb begin
		if (err) begin
			st_adv  = st;
			err_adv = 1'b1;
			code_e  = '0;
		end else if (fail) begin
			st_adv  = ST_IDLE;
			err_adv = 1'b1;
			code_e  = '0;
		end else begin
			st_adv  = nx;
			err_adv = 1'b0;
			code_e  = code;
		end
		err_fin = err_adv | (last & (st_adv != ST_IDLE));

		m.emit           = (code_e != '0) | last;
		m.res.code_char  = code_e;
		m.res.code_valid = (code_e != '0);
		m.res.done_res   = last;
		m.res.bad_input  = last & err_fin;
		m.st             = last ? ST_IDLE : st_adv;
		m.err            = last ? 1'b0 : err_fin;
	end

endmodule

### rtl/ckl_result_reg.sv
// ----------------------------------------------------------------------------
// ckl_result_reg
// Output register of the lexer; takes a new result whenever it is free or
// being drained.
// ----------------------------------------------------------------------------
module ckl_result_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  ckl_pkg::res_t    res_d,
	output logic             can_load,
	ckl_out_if.source        codes
);
	import ckl_pkg::*;

	logic valid_q;
	res_t res_q;

	assign can_load = !valid_q || codes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (codes.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign codes.valid      = valid_q;
	assign codes.code_char  = res_q.code_char;
	assign codes.code_valid = res_q.code_valid;
	assign codes.done_res   = res_q.done_res;
	assign codes.bad_input  = res_q.bad_input;

endmodule

### rtl/calc_keyword_lexer.sv
// ----------------------------------------------------------------------------
// calc_keyword_lexer
// Character-stream lexer for calculator expressions with keyword matching.
// ----------------------------------------------------------------------------
// Usage:
//   chars : one character per item (in_char), in_last set on the final one.
//   codes : a result item for every character that yields a token code and
//           for every last character; done_res/bad_input report the end of
//           an expression. Characters giving no token produce no item.
// Path: a character is held in the input register and its result is loaded
//   into the result register once that register can take it; codes then
//   takes it from there (input register, then result register).
// Throughput: one character per cycle while codes is not stalled; the prefix
//   machine and the error flag are updated as each character leaves the input register.
// Reset: clears both registers' valid flags, sets the prefix machine to idle
//   and clears the error flag. State also returns to idle after each last
//   character.
// Stall: while the result register holds an untaken item the input register
//   keeps its character; chars.ready drops only when both are full and codes
//   is stalled.
// ----------------------------------------------------------------------------
`include "calc_keyword_lexer_defines.svh"

module calc_keyword_lexer (
	input  logic       clk,
	input  logic       arst_n,
	ckl_in_if.sink     chars,
	ckl_out_if.source  codes
);
	import ckl_pkg::*;

	logic       v_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	state_t     st_q;
	logic       err_q;
	match_t     m;
	logic       can_load;
	logic       take_s1;

	assign take_s1     = v_s1 && can_load;
	assign chars.ready = !v_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			v_s1 <= 1'b1;
		end else if (take_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1   <= chars.in_char;
			last_s1 <= chars.in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			err_q <= 1'b0;
		end else if (take_s1) begin
			st_q  <= m.st;
			err_q <= m.err;
		end
	end

	ckl_matcher u_matcher (
		.st   (st_q),
		.err  (err_q),
		.ch   (ch_s1),
		.last (last_s1),
		.m    (m)
	);

	ckl_result_reg u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take_s1 && m.emit),
		.res_d    (m.res),
		.can_load (can_load),
		.codes    (codes)
	);

	`CKL_ASSERT(a_state_onehot, clk, arst_n, $onehot(st_q))
	`CKL_ASSERT(a_last_clears, clk, arst_n,
		(take_s1 && last_s1) |=> (st_q == ST_IDLE && !err_q))
	`CKL_NEVER(a_code_with_error, clk, arst_n,
		codes.valid && codes.code_valid && codes.bad_input)
	`CKL_NEVER(a_ready_when_full, clk, arst_n,
		chars.ready && v_s1 && codes.valid && !codes.ready)

endmodule
